### rtl/rvex_pkg.sv
// ============================================================================
// rvex_pkg
// Shared types, opcodes and function codes for the RV32IM execute unit.
// ============================================================================
package rvex_pkg;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_AW    = $clog2(REG_COUNT);
    localparam int CNT_W     = $clog2(XLEN);

    typedef struct packed {
        logic [31:0] instruction_word;
        logic [31:0] instruction_address;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_address;
        logic        write_enable;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        illegal;
    } t_out_item;

    // major opcodes
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_FENCE  = 7'h0f;

    // funct7
    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    // funct3, base ALU
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3, M extension
    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_DIVU   = 3'd5;
    localparam logic [2:0] F3_REM    = 3'd6;
    localparam logic [2:0] F3_REMU   = 3'd7;

    // funct3, branches
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // funct3, fence
    localparam logic [2:0] F3_FENCE  = 3'd0;
    localparam logic [2:0] F3_FENCEI = 3'd1;

    typedef enum logic [2:0] {
        ALU_ADD  = 3'd0,
        ALU_SUB  = 3'd1,
        ALU_SLT  = 3'd2,
        ALU_SLTU = 3'd3,
        ALU_XOR  = 3'd4,
        ALU_OR   = 3'd5,
        ALU_AND  = 3'd6
    } t_alu_op;

    typedef enum logic [1:0] {
        SH_SLL = 2'd0,
        SH_SRL = 2'd1,
        SH_SRA = 2'd2
    } t_shift_kind;

    typedef struct packed {
        logic eq;
        logic lt;
        logic ltu;
    } t_cmp_flags;

endpackage

### rtl/rv32im_execute_unit.sv
// ============================================================================
// rv32im_execute_unit
// RV32IM integer execute unit with bit-serial datapath and register file.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one
//   instruction word and its pc per transaction. Output channel
//   (o_out_valid / i_out_stall / o_out_data) returns one transaction per
//   instruction: next pc, register writeback and the illegal flag.
//   One instruction is in flight at a time. After acceptance the unit
//   reads the register file, loads the operands, then runs the serial
//   lanes one bit per cycle, with the shifter or the multiply/divide
//   unit alongside when used; the multiply ends with correction steps for
//   the signed high forms, and its loop sets the worst case. The result
//   goes to a holding register, then to the output register, and the
//   next instruction is taken after that.
//   The output register decouples the sides: the next instruction is taken
//   while a finished result is still stalled, and a second result waits in
//   a holding register until the output frees.
//   Synchronous reset clears the control state and marks every register
//   file entry as zero at once; no clearing pass is needed.
// ============================================================================
module rv32im_execute_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rvex_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rvex_pkg::t_out_item o_out_data
);
    import rvex_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_LOAD = 5'b00100,
        S_RUN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state      r_state;
    logic [31:0] r_word;
    logic [31:0] r_pc;
    logic        r_lane_done;
    logic        r_aux_done;
    t_out_item   r_pend;
    t_out_item   r_out;
    logic        r_out_valid;

    // instruction fields
    logic [6:0]  opc;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic        rd_ok, rs1_ok, rs2_ok;
    logic [31:0] imm_i, imm_u, imm_j, imm_b;

    // decode results
    logic        legal, has_rd, use_shift, use_mdu;
    t_alu_op     alu_op;
    logic [31:0] alu_x, alu_y, tgt_off;
    t_shift_kind sh_kind;
    logic [CNT_W-1:0] sh_amt;

    // datapath
    logic [31:0] rf_a, rf_b;
    logic        rf_we;
    logic        d0, d1, d2, sh_done, md_done;
    logic [31:0] res0, res1, res2, sh_res, md_res;
    t_cmp_flags  flags0, flags1, flags2;
    logic        take, wr, finish, lane_now, aux_now;
    logic [31:0] val, next_pc;
    t_out_item   item;
    logic        in_fire, out_fire, slot_free;

    assign in_fire    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_fire   = r_out_valid && !i_out_stall;
    assign slot_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        opc    = r_word[6:0];
        rd     = r_word[11:7];
        f3     = r_word[14:12];
        rs1    = r_word[19:15];
        rs2    = r_word[24:20];
        f7     = r_word[31:25];
        rd_ok  = ({1'b0, rd}  < 6'(REG_COUNT));
        rs1_ok = ({1'b0, rs1} < 6'(REG_COUNT));
        rs2_ok = ({1'b0, rs2} < 6'(REG_COUNT));
        imm_i  = {{20{r_word[31]}}, r_word[31:20]};
        imm_u  = {r_word[31:12], 12'd0};
        imm_j  = {{12{r_word[31]}}, r_word[19:12], r_word[20], r_word[30:21], 1'b0};
        imm_b  = {{20{r_word[31]}}, r_word[7], r_word[30:25], r_word[11:8], 1'b0};
    end

    // decode: legality, lane operands and engine selection
    always_comb begin
        legal     = 1'b0;
        has_rd    = 1'b0;
        use_shift = 1'b0;
        use_mdu   = 1'b0;
        alu_op    = ALU_ADD;
        alu_x     = '0;
        alu_y     = '0;
        tgt_off   = imm_b;
        sh_kind   = (f3 == F3_SLL) ? SH_SLL : (r_word[30] ? SH_SRA : SH_SRL);
        sh_amt    = rs2;
        unique case (opc)
            OPC_OP: begin
                legal  = rd_ok && rs1_ok && rs2_ok &&
                         ((f7 == F7_BASE) || (f7 == F7_MULDIV) ||
                          ((f7 == F7_ALT) && ((f3 == F3_ADD) || (f3 == F3_SR))));
                has_rd = 1'b1;
                alu_x  = rf_a;
                alu_y  = rf_b;
                sh_amt = rf_b[CNT_W-1:0];
                if (f7 == F7_MULDIV) begin
                    use_mdu = 1'b1;
                end else if ((f3 == F3_SLL) || (f3 == F3_SR)) begin
                    use_shift = 1'b1;
                end
                unique case (f3)
                    F3_ADD:  alu_op = (f7 == F7_ALT) ? ALU_SUB : ALU_ADD;
                    F3_SLT:  alu_op = ALU_SLT;
                    F3_SLTU: alu_op = ALU_SLTU;
                    F3_XOR:  alu_op = ALU_XOR;
                    F3_OR:   alu_op = ALU_OR;
                    F3_AND:  alu_op = ALU_AND;
                    default: alu_op = ALU_ADD;
                endcase
            end
            OPC_OPIMM: begin
                has_rd = 1'b1;
                alu_x  = rf_a;
                alu_y  = imm_i;
                if (f3 == F3_SLL) begin
                    legal = rd_ok && rs1_ok && (f7 == F7_BASE);
                end else if (f3 == F3_SR) begin
                    legal = rd_ok && rs1_ok && ((f7 == F7_BASE) || (f7 == F7_ALT));
                end else begin
                    legal = rd_ok && rs1_ok;
                end
                use_shift = (f3 == F3_SLL) || (f3 == F3_SR);
                unique case (f3)
                    F3_SLT:  alu_op = ALU_SLT;
                    F3_SLTU: alu_op = ALU_SLTU;
                    F3_XOR:  alu_op = ALU_XOR;
                    F3_OR:   alu_op = ALU_OR;
                    F3_AND:  alu_op = ALU_AND;
                    default: alu_op = ALU_ADD;
                endcase
            end
            OPC_LUI: begin
                legal  = rd_ok;
                has_rd = 1'b1;
                alu_y  = imm_u;
            end
            OPC_AUIPC: begin
                legal  = rd_ok;
                has_rd = 1'b1;
                alu_x  = r_pc;
                alu_y  = imm_u;
            end
            OPC_JAL: begin
                legal   = rd_ok;
                has_rd  = 1'b1;
                tgt_off = imm_j;
            end
            OPC_JALR: begin
                legal  = (f3 == F3_ADD) && rd_ok && rs1_ok;
                has_rd = 1'b1;
                alu_x  = rf_a;
                alu_y  = imm_i;
            end
            OPC_BRANCH: begin
                legal  = (f3 != F3_SLT) && (f3 != F3_SLTU) && rs1_ok && rs2_ok;
                alu_op = ALU_SUB;
                alu_x  = rf_a;
                alu_y  = rf_b;
            end
            OPC_FENCE: begin
                legal = (f3 == F3_FENCE) || (f3 == F3_FENCEI);
            end
            default: legal = 1'b0;
        endcase
    end

    rvex_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_re      (r_state == S_READ),
        .i_raddr_a (rs1[REG_AW-1:0]),
        .i_raddr_b (rs2[REG_AW-1:0]),
        .o_rdata_a (rf_a),
        .o_rdata_b (rf_b),
        .i_we      (rf_we),
        .i_waddr   (rd[REG_AW-1:0]),
        .i_wdata   (val)
    );

    // lane 0: main ALU, lane 1: pc + 4, lane 2: pc + branch/jump offset
    rvex_serial_alu u_lane_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_LOAD),
        .i_op     (alu_op),
        .i_x      (alu_x),
        .i_y      (alu_y),
        .o_done   (d0),
        .o_result (res0),
        .o_flags  (flags0)
    );

    rvex_serial_alu u_lane_link (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_LOAD),
        .i_op     (ALU_ADD),
        .i_x      (r_pc),
        .i_y      (32'd4),
        .o_done   (d1),
        .o_result (res1),
        .o_flags  (flags1)
    );

    rvex_serial_alu u_lane_target (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_LOAD),
        .i_op     (ALU_ADD),
        .i_x      (r_pc),
        .i_y      (tgt_off),
        .o_done   (d2),
        .o_result (res2),
        .o_flags  (flags2)
    );

    rvex_shifter u_shifter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  ((r_state == S_LOAD) && use_shift),
        .i_kind   (sh_kind),
        .i_value  (rf_a),
        .i_amount (sh_amt),
        .o_done   (sh_done),
        .o_result (sh_res)
    );

    rvex_mdu u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  ((r_state == S_LOAD) && use_mdu),
        .i_funct3 (f3),
        .i_a      (rf_a),
        .i_b      (rf_b),
        .o_done   (md_done),
        .o_result (md_res)
    );

    // completion: all three lanes plus the shifter or MDU when used
    always_comb begin
        lane_now = r_lane_done || (d0 && d1 && d2);
        aux_now  = r_aux_done || sh_done || md_done;
        finish   = (r_state == S_RUN) && lane_now && aux_now;
    end

    // result assembly
    always_comb begin
        unique case (f3)
            F3_BEQ:  take = flags0.eq;
            F3_BNE:  take = !flags0.eq;
            F3_BLT:  take = flags0.lt;
            F3_BGE:  take = !flags0.lt;
            F3_BLTU: take = flags0.ltu;
            F3_BGEU: take = !flags0.ltu;
            default: take = 1'b0;
        endcase

        if (use_mdu) begin
            val = md_res;
        end else if (use_shift) begin
            val = sh_res;
        end else if ((opc == OPC_JAL) || (opc == OPC_JALR)) begin
            val = res1;
        end else begin
            val = res0;
        end

        unique case (opc)
            OPC_JAL:    next_pc = res2;
            OPC_JALR:   next_pc = {res0[31:1], 1'b0};
            OPC_BRANCH: next_pc = take ? res2 : res1;
            default:    next_pc = res1;
        endcase

        wr                = legal && has_rd && (rd != '0);
        item.next_address = legal ? next_pc : res1;
        item.write_enable = wr;
        item.dest_index   = wr ? rd : '0;
        item.dest_value   = wr ? val : '0;
        item.illegal      = !legal;
        rf_we             = finish && wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lane_done <= 1'b0;
            r_aux_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (in_fire) r_state <= S_READ;
                S_READ: r_state <= S_LOAD;
                S_LOAD: begin
                    r_lane_done <= 1'b0;
                    r_aux_done  <= !(use_shift || use_mdu);
                    r_state     <= S_RUN;
                end
                S_RUN: begin
                    r_lane_done <= lane_now;
                    r_aux_done  <= aux_now;
                    if (finish) r_state <= S_OUT;
                end
                S_OUT: if (slot_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase

            if ((r_state == S_OUT) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_word <= i_in_data.instruction_word;
            r_pc   <= i_in_data.instruction_address;
        end
        if (finish) begin
            r_pend <= item;
        end
        if ((r_state == S_OUT) && slot_free) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_READ))
        else $error("accepted transaction did not start a register read");

    a_write_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> (r_state == S_RUN))
        else $error("register file written outside completion");

    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && !slot_free) |=> (r_state == S_OUT))
        else $error("pending result dropped while output stalled");

    a_illegal_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.illegal) |-> !o_out_data.write_enable)
        else $error("illegal instruction reported a writeback");

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.write_enable) |-> (o_out_data.dest_index != '0))
        else $error("writeback reported for x0");
`endif

endmodule

### rtl/rvex_regfile.sv
// ============================================================================
// rvex_regfile
// Integer register file: one write port, two registered read ports.
// ============================================================================
module rvex_regfile (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_re,
    input  logic [rvex_pkg::REG_AW-1:0] i_raddr_a,
    input  logic [rvex_pkg::REG_AW-1:0] i_raddr_b,
    output logic [31:0]               o_rdata_a,
    output logic [31:0]               o_rdata_b,
    input  logic                      i_we,
    input  logic [rvex_pkg::REG_AW-1:0] i_waddr,
    input  logic [31:0]               i_wdata
);
    import rvex_pkg::*;

    logic [31:0]          r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_valid;
    logic [31:0]          r_data_a;
    logic [31:0]          r_data_b;
    logic                 r_hit_a;
    logic                 r_hit_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_data_a <= r_mem[i_raddr_a];
            r_data_b <= r_mem[i_raddr_b];
        end
    end

    // never-written entries and x0 read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit_a <= 1'b0;
            r_hit_b <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_hit_a <= r_valid[i_raddr_a] && (i_raddr_a != '0);
                r_hit_b <= r_valid[i_raddr_b] && (i_raddr_b != '0);
            end
        end
    end

    assign o_rdata_a = r_hit_a ? r_data_a : '0;
    assign o_rdata_b = r_hit_b ? r_data_b : '0;

endmodule

### rtl/rvex_serial_alu.sv
// ============================================================================
// rvex_serial_alu
// Bit-serial ALU lane: one bit per cycle, LSB first, plus compare flags.
// ============================================================================
module rvex_serial_alu (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  rvex_pkg::t_alu_op    i_op,
    input  logic [31:0]          i_x,
    input  logic [31:0]          i_y,
    output logic                 o_done,
    output logic [31:0]          o_result,
    output rvex_pkg::t_cmp_flags o_flags
);
    import rvex_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_alu_op          r_op;
    logic [31:0]      r_x;
    logic [31:0]      r_y;
    logic [31:0]      r_res;
    logic             r_c;
    logic             r_neq;
    logic             r_lt;
    logic             r_ltu;

    logic x_bit, y_bit, y_eff, sub, sum, cout, res_bit, last;

    always_comb begin
        sub   = (r_op == ALU_SUB) || (r_op == ALU_SLT) || (r_op == ALU_SLTU);
        x_bit = r_x[0];
        y_bit = r_y[0];
        y_eff = y_bit ^ sub;
        sum   = x_bit ^ y_eff ^ r_c;
        cout  = (x_bit & y_eff) | (x_bit & r_c) | (y_eff & r_c);
        last  = (r_cnt == CNT_W'(XLEN - 1));
        unique case (r_op)
            ALU_XOR: res_bit = x_bit ^ y_bit;
            ALU_OR:  res_bit = x_bit | y_bit;
            ALU_AND: res_bit = x_bit & y_bit;
            default: res_bit = sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_x   <= i_x;
            r_y   <= i_y;
            r_c   <= (i_op == ALU_SUB) || (i_op == ALU_SLT) || (i_op == ALU_SLTU);
            r_neq <= 1'b0;
        end else if (r_busy) begin
            r_x   <= {1'b0, r_x[31:1]};
            r_y   <= {1'b0, r_y[31:1]};
            r_res <= {res_bit, r_res[31:1]};
            r_c   <= cout;
            r_neq <= r_neq | (x_bit ^ y_bit);
            if (last) begin
                // sign bits are on the wire in the last cycle
                r_lt  <= (x_bit != y_bit) ? x_bit : sum;
                r_ltu <= !cout;
            end
        end
    end

    always_comb begin
        unique case (r_op)
            ALU_SLT:  o_result = {31'd0, r_lt};
            ALU_SLTU: o_result = {31'd0, r_ltu};
            default:  o_result = r_res;
        endcase
    end

    assign o_done  = r_done;
    assign o_flags = '{eq: !r_neq, lt: r_lt, ltu: r_ltu};

endmodule

### rtl/rvex_shifter.sv
// ============================================================================
// rvex_shifter
// Serial shifter: moves the value one position per cycle.
// ============================================================================
module rvex_shifter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  rvex_pkg::t_shift_kind i_kind,
    input  logic [31:0]           i_value,
    input  logic [rvex_pkg::CNT_W-1:0] i_amount,
    output logic                  o_done,
    output logic [31:0]           o_result
);
    import rvex_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_shift_kind      r_kind;
    logic [31:0]      r_val;
    logic [31:0]      n_val;

    always_comb begin
        unique case (r_kind)
            SH_SLL:  n_val = {r_val[30:0], 1'b0};
            SH_SRA:  n_val = {r_val[31], r_val[31:1]};
            default: n_val = {1'b0, r_val[31:1]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_amount;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_kind <= i_kind;
        end else if (r_busy && (r_cnt != '0)) begin
            r_val <= n_val;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_val;

endmodule

### rtl/rvex_mdu.sv
// ============================================================================
// rvex_mdu
// Multiply / divide unit: shift-add multiply and restoring divide, one
// operand bit per cycle.
// ============================================================================
module rvex_mdu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [2:0]  i_funct3,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_result
);
    import rvex_pkg::*;

    typedef enum logic [5:0] {
        M_IDLE   = 6'b000001,
        M_MUL    = 6'b000010,
        M_FIX1   = 6'b000100,
        M_FIX2   = 6'b001000,
        M_DIV    = 6'b010000,
        M_FINISH = 6'b100000
    } t_mstate;

    t_mstate          r_state;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [2:0]       r_f3;
    logic [31:0]      r_hi;     // product high / partial remainder
    logic [31:0]      r_lo;     // product low / quotient
    logic [31:0]      r_ma;     // multiplicand / divisor magnitude
    logic [31:0]      r_b;
    logic             r_na;
    logic             r_nb;
    logic             r_bz;
    logic [31:0]      r_res;

    logic        is_mul, sgn_div, last;
    logic [32:0] mul_sum;
    logic [32:0] div_sh;
    logic [33:0] div_diff;
    logic        div_ge;

    always_comb begin
        is_mul   = !i_funct3[2];
        sgn_div  = (i_funct3 == F3_DIV) || (i_funct3 == F3_REM);
        last     = (r_cnt == CNT_W'(XLEN - 1));
        mul_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_ma} : 33'd0);
        div_sh   = {r_hi, r_lo[31]};
        div_diff = {1'b0, div_sh} - {2'b00, r_ma};
        div_ge   = !div_diff[33];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_start) begin
                        r_cnt   <= '0;
                        r_state <= is_mul ? M_MUL : M_DIV;
                    end
                end
                M_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (last) begin
                        r_state <= M_FIX1;
                    end
                end
                M_FIX1: r_state <= M_FIX2;
                M_FIX2: r_state <= M_FINISH;
                M_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (last) begin
                        r_state <= M_FINISH;
                    end
                end
                M_FINISH: begin
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    r_f3 <= i_funct3;
                    r_b  <= i_b;
                    r_na <= i_a[31];
                    r_nb <= i_b[31];
                    r_bz <= (i_b == '0);
                    r_hi <= '0;
                    if (is_mul) begin
                        r_lo <= i_b;
                        r_ma <= i_a;
                    end else begin
                        r_lo <= (sgn_div && i_a[31]) ? (32'd0 - i_a) : i_a;
                        r_ma <= (sgn_div && i_b[31]) ? (32'd0 - i_b) : i_b;
                    end
                end
            end
            M_MUL: begin
                r_hi <= mul_sum[32:1];
                r_lo <= {mul_sum[0], r_lo[31:1]};
            end
            M_FIX1: begin
                // signed multiplicand: take b back out of the high word
                if (((r_f3 == F3_MULH) || (r_f3 == F3_MULHSU)) && r_na) begin
                    r_hi <= r_hi - r_b;
                end
            end
            M_FIX2: begin
                if ((r_f3 == F3_MULH) && r_nb) begin
                    r_hi <= r_hi - r_ma;
                end
            end
            M_DIV: begin
                r_hi <= div_ge ? div_diff[31:0] : div_sh[31:0];
                r_lo <= {r_lo[30:0], div_ge};
            end
            M_FINISH: begin
                unique case (r_f3)
                    F3_MUL:  r_res <= r_lo;
                    F3_DIV:  r_res <= r_bz ? '1 : ((r_na != r_nb) ? (32'd0 - r_lo) : r_lo);
                    F3_DIVU: r_res <= r_bz ? '1 : r_lo;
                    F3_REM:  r_res <= r_na ? (32'd0 - r_hi) : r_hi;
                    F3_REMU: r_res <= r_hi;
                    default: r_res <= r_hi;
                endcase
            end
            default: ;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
